### src/qphs_pkg.sv
// Shared types and codes for the quadratic probe hash set.
package qphs_pkg;

   // Request kinds carried on req_tuser; any other code is a lookup.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Result codes.
   localparam logic [1:0] RC_OK      = 2'd0;
   localparam logic [1:0] RC_DUP     = 2'd1;
   localparam logic [1:0] RC_ABSENT  = 2'd2;
   localparam logic [1:0] RC_REFUSED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_MAX_LOAD = 1'b0;
   localparam logic CSR_MIN_LOAD = 1'b1;

   // Fixed field widths of the streams.
   localparam int OP_W    = 2;
   localparam int FKEY_W  = 32;
   localparam int HASH_W  = 32;
   localparam int COUNT_W = 11;
   localparam int LOAD_W  = 8;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME_RD,
      ST_HOME,
      ST_PROBE_RD,
      ST_PROBE,
      ST_DECIDE,
      ST_LOAD_CHK,
      ST_GATHER_RD,
      ST_GATHER,
      ST_WIPE,
      ST_SCR_RD,
      ST_SCR,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

### src/qphs_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module qphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/quadratic_probe_hash_set.sv
// Top level of the quadratic probe hash set: sequencer, memories and stream ports.
//
// An open-addressing set of nonzero keys held in on-chip RAM. Each request inserts, erases
// or looks up one key with its precomputed hash, and yields exactly one response carrying
// success, a result code, the key count and the table capacity after the request. One
// request is worked on at a time, and the pace is set by the single read port of the slot
// RAM, which is read and then checked for each probe. A request with key zero is answered
// without any table access, and a lookup or erase whose home slot count is zero is answered
// without a probe. An insert whose home count is zero stops at the first free slot; any
// other insert stops on its key or walks the whole table. A lookup or erase on a populated
// home slot probes until it finds its key, and an erase that finds it then goes through
// the load check; a miss on a populated home slot walks the whole table. A stalled
// response holds the block until it is taken. When a request crosses a load threshold the
// table is rebuilt in place: the live keys are gathered into scratch, both RAMs are wiped,
// then each key is put back at the first free slot on its probe path. After reset the
// block sweeps both RAMs before it takes its first request; configuration writes are taken
// during that sweep. max_load and min_load may be written only while no request is
// outstanding.
module quadratic_probe_hash_set #(
   parameter int INITIAL_CAPACITY = 16,
   parameter int MAX_CAPACITY     = 1024,
   parameter int KEY_WIDTH        = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qphs_pkg::REQ_DATA_W-1:0]   req_tdata,  // key [31:0], key_hash [63:32]
   input  logic [qphs_pkg::OP_W-1:0]         req_tuser,  // operation [1:0]
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // success [0], result_code [2:1], item_count [13:3], table_capacity [24:14], zeros above
   output logic [qphs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [qphs_pkg::LOAD_W-1:0]       csr_wdata
);

   import qphs_pkg::*;

   localparam int IW = $clog2(MAX_CAPACITY);          // slot index width
   localparam int CW = IW + 1;                        // counts up to the capacity
   localparam int KW = (KEY_WIDTH < FKEY_W) ? KEY_WIDTH : FKEY_W;
   localparam int XW = KW + HASH_W;                   // {hash, key}
   localparam int SW = XW + 1;                        // {hash, key, used}
   localparam int PW = CW + LOAD_W;                   // load product width

   // Sequencer state and per-request registers.
   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [CW-1:0]     hc_ff, hc_in;          // home slot count read for this key
   logic [IW-1:0]     pos_ff, pos_in;        // current probe slot
   logic [CW-1:0]     i_ff, i_in;            // probe number
   logic              found_ff, found_in;
   logic [IW-1:0]     fpos_ff, fpos_in;
   logic              free_ok_ff, free_ok_in;
   logic [IW-1:0]     free_ff, free_in;      // first free slot on the probe path
   logic              mode_free_ff, mode_free_in;
   logic              rehash_ff, rehash_in;
   logic              ok_ff, ok_in;
   logic [1:0]        code_ff, code_in;
   logic [CW-1:0]     keys_ff, keys_in;
   logic [CW-1:0]     cap_ff, cap_in;
   logic [CW-1:0]     newcap_ff, newcap_in;
   logic [CW-1:0]     j_ff, j_in;            // sweep index
   logic [CW-1:0]     n_ff, n_in;            // keys gathered into scratch
   logic [CW-1:0]     k_ff, k_in;            // scratch entry being placed
   logic [LOAD_W-1:0] max_load_ff, max_load_in;
   logic [LOAD_W-1:0] min_load_ff, min_load_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic          slot_we;
   logic [IW-1:0] slot_waddr, slot_raddr;
   logic [SW-1:0] slot_wdata, slot_rd;
   logic          home_we;
   logic [IW-1:0] home_waddr, home_raddr;
   logic [CW-1:0] home_wdata, home_rd;
   logic          scr_we;
   logic [IW-1:0] scr_waddr, scr_raddr;
   logic [XW-1:0] scr_wdata, scr_rd;

   // Derived values.
   logic          req_fire, out_free, key_zero, is_ins, is_era;
   logic [IW-1:0] mask_w, home_w, pos_next;
   logic          sl_used, match_w, probe_done;
   logic [CW-1:0] i_inc;
   logic [PW-1:0] load_lhs, load_rhs;
   logic          over_w, grow_ok, shrink_ok, rehash_go, j_last;

   qphs_ram #(.WIDTH(SW), .DEPTH(MAX_CAPACITY)) u_slot (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rd));

   qphs_ram #(.WIDTH(CW), .DEPTH(MAX_CAPACITY)) u_home (
      .clock(clock), .wr_en(home_we), .wr_addr(home_waddr), .wr_data(home_wdata),
      .rd_addr(home_raddr), .rd_data(home_rd));

   qphs_ram #(.WIDTH(XW), .DEPTH(MAX_CAPACITY)) u_scratch (
      .clock(clock), .wr_en(scr_we), .wr_addr(scr_waddr), .wr_data(scr_wdata),
      .rd_addr(scr_raddr), .rd_data(scr_rd));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign key_zero   = (req_tdata[KW-1:0] == '0);
   assign is_ins     = (op_ff == OP_INSERT);
   assign is_era     = (op_ff == OP_ERASE);

   // The capacity is a power of two, so the slot number is the masked sum.
   assign mask_w   = IW'(cap_ff - CW'(1));
   assign home_w   = hash_ff[IW-1:0] & mask_w;
   assign i_inc    = i_ff + CW'(1);
   // Triangular probing: offset(i+1) = offset(i) + i + 1.
   assign pos_next = (pos_ff + IW'(i_inc)) & mask_w;

   // A probe stops on the key, on a free slot when only a free slot is wanted,
   // or after every slot of the table has been visited.
   assign sl_used    = slot_rd[0];
   assign match_w    = sl_used && (slot_rd[KW:1] == key_ff) && !mode_free_ff;
   assign probe_done = match_w || (mode_free_ff && !sl_used) || (i_inc == cap_ff);

   // Load check after the count has been updated: keys*256 against load*capacity.
   assign load_lhs  = {keys_ff, {LOAD_W{1'b0}}};
   assign load_rhs  = PW'(is_ins ? max_load_ff : min_load_ff) * PW'(cap_ff);
   assign over_w    = is_ins ? (load_lhs >= load_rhs) : (load_lhs <= load_rhs);
   assign grow_ok   = (cap_ff < CW'(MAX_CAPACITY));
   assign shrink_ok = (cap_ff > CW'(1)) && (keys_ff <= (cap_ff >> 1));
   assign rehash_go = over_w && (is_ins ? grow_ok : shrink_ok);
   assign j_last    = (j_ff[IW-1:0] == {IW{1'b1}});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (j_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_fire) state_in = key_zero ? ST_DONE : ST_HOME_RD;
         ST_HOME_RD:   state_in = ST_HOME;
         ST_HOME: begin
            if (rehash_ff || is_ins || (home_rd != '0)) state_in = ST_PROBE_RD;
            else state_in = ST_DECIDE;
         end
         ST_PROBE_RD:  state_in = ST_PROBE;
         ST_PROBE: begin
            if (probe_done) state_in = rehash_ff ? ST_PLACE : ST_DECIDE;
            else state_in = ST_PROBE_RD;
         end
         ST_DECIDE: begin
            if (is_ins) state_in = (found_ff || keys_ff >= cap_ff) ? ST_DONE : ST_LOAD_CHK;
            else if (is_era) state_in = found_ff ? ST_LOAD_CHK : ST_DONE;
            else state_in = ST_DONE;
         end
         ST_LOAD_CHK:  state_in = rehash_go ? ST_GATHER_RD : ST_DONE;
         ST_GATHER_RD: state_in = ST_GATHER;
         ST_GATHER:    state_in = ((j_ff + CW'(1)) == cap_ff) ? ST_WIPE : ST_GATHER_RD;
         ST_WIPE:      if (j_last) state_in = (n_ff == '0) ? ST_DONE : ST_SCR_RD;
         ST_SCR_RD:    state_in = ST_SCR;
         ST_SCR:       state_in = ST_HOME_RD;
         ST_PLACE:     state_in = ((k_ff + CW'(1)) == n_ff) ? ST_DONE : ST_SCR_RD;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   // Datapath, RAM controls and outputs.
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      hc_in        = hc_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;
      free_ok_in   = free_ok_ff;
      free_in      = free_ff;
      mode_free_in = mode_free_ff;
      rehash_in    = rehash_ff;
      ok_in        = ok_ff;
      code_in      = code_ff;
      keys_in      = keys_ff;
      cap_in       = cap_ff;
      newcap_in    = newcap_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_raddr = '0;
      home_we    = 1'b0;
      home_waddr = '0;
      home_wdata = '0;
      home_raddr = '0;
      scr_we     = 1'b0;
      scr_waddr  = '0;
      scr_wdata  = '0;
      scr_raddr  = '0;

      max_load_in = max_load_ff;
      min_load_in = min_load_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LOAD: max_load_in = csr_wdata;
            CSR_MIN_LOAD: min_load_in = csr_wdata;
            default:      max_load_in = max_load_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR, ST_WIPE: begin
            // Free every slot and zero every home count, one entry a cycle.
            slot_we    = 1'b1;
            slot_waddr = j_ff[IW-1:0];
            home_we    = 1'b1;
            home_waddr = j_ff[IW-1:0];
            j_in       = j_ff + CW'(1);
            if (j_last) begin
               j_in = '0;
               if (state_ff == ST_WIPE) begin
                  cap_in    = newcap_ff;
                  keys_in   = n_ff;
                  k_in      = '0;
                  rehash_in = 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               key_in    = req_tdata[KW-1:0];
               hash_in   = req_tdata[FKEY_W +: HASH_W];
               rehash_in = 1'b0;
               ok_in     = 1'b0;
               code_in   = key_zero ? RC_ABSENT : RC_OK;
            end
         end
         ST_HOME_RD: home_raddr = home_w;
         ST_HOME: begin
            hc_in        = home_rd;
            pos_in       = home_w;
            i_in         = '0;
            found_in     = 1'b0;
            free_ok_in   = 1'b0;
            // An insert whose home count is zero cannot find a duplicate, and a
            // rebuild never can: both only look for the first free slot.
            mode_free_in = rehash_ff || (is_ins && (home_rd == '0));
         end
         ST_PROBE_RD: slot_raddr = pos_ff;
         ST_PROBE: begin
            if (!sl_used && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = pos_ff;
            end
            if (match_w) begin
               found_in = 1'b1;
               fpos_in  = pos_ff;
            end
            pos_in = pos_next;
            i_in   = i_inc;
         end
         ST_DECIDE: begin
            if (is_ins) begin
               if (found_ff) begin
                  code_in = RC_DUP;
               end else if (keys_ff >= cap_ff) begin
                  code_in = RC_REFUSED;
               end else begin
                  slot_we    = 1'b1;
                  slot_waddr = free_ff;
                  slot_wdata = {hash_ff, key_ff, 1'b1};
                  home_we    = 1'b1;
                  home_waddr = home_w;
                  home_wdata = hc_ff + CW'(1);
                  keys_in    = keys_ff + CW'(1);
                  ok_in      = 1'b1;
               end
            end else if (is_era) begin
               if (found_ff) begin
                  slot_we    = 1'b1;
                  slot_waddr = fpos_ff;
                  slot_wdata = {hash_ff, key_ff, 1'b0};
                  home_we    = 1'b1;
                  home_waddr = home_w;
                  home_wdata = hc_ff - CW'(1);
                  keys_in    = keys_ff - CW'(1);
                  ok_in      = 1'b1;
               end else begin
                  code_in = RC_ABSENT;
               end
            end else begin
               ok_in   = found_ff;
               code_in = found_ff ? RC_OK : RC_ABSENT;
            end
         end
         ST_LOAD_CHK: begin
            if (over_w && !rehash_go) code_in = RC_REFUSED;
            newcap_in = is_ins ? (cap_ff << 1) : (cap_ff >> 1);
            j_in      = '0;
            n_in      = '0;
         end
         ST_GATHER_RD: slot_raddr = j_ff[IW-1:0];
         ST_GATHER: begin
            // Live keys are packed into scratch in ascending slot order.
            if (sl_used) begin
               scr_we    = 1'b1;
               scr_waddr = n_ff[IW-1:0];
               scr_wdata = slot_rd[SW-1:1];
               n_in      = n_ff + CW'(1);
            end
            j_in = ((j_ff + CW'(1)) == cap_ff) ? '0 : (j_ff + CW'(1));
         end
         ST_SCR_RD: scr_raddr = k_ff[IW-1:0];
         ST_SCR: begin
            key_in  = scr_rd[KW-1:0];
            hash_in = scr_rd[XW-1:KW];
         end
         ST_PLACE: begin
            slot_we    = 1'b1;
            slot_waddr = free_ff;
            slot_wdata = {hash_ff, key_ff, 1'b1};
            home_we    = 1'b1;
            home_waddr = home_w;
            home_wdata = hc_ff + CW'(1);
            k_in       = k_ff + CW'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - 2*COUNT_W - 3){1'b0}},
                               COUNT_W'(cap_ff), COUNT_W'(keys_ff), code_ff, ok_ff};
            end
         end
         default: j_in = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         keys_ff      <= '0;
         cap_ff       <= CW'(INITIAL_CAPACITY);
         j_ff         <= '0;
         rehash_ff    <= 1'b0;
         max_load_ff  <= LOAD_W'(192);
         min_load_ff  <= LOAD_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         keys_ff      <= keys_in;
         cap_ff       <= cap_in;
         j_ff         <= j_in;
         rehash_ff    <= rehash_in;
         max_load_ff  <= max_load_in;
         min_load_ff  <= min_load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      hash_ff      <= hash_in;
      hc_ff        <= hc_in;
      pos_ff       <= pos_in;
      i_ff         <= i_in;
      found_ff     <= found_in;
      fpos_ff      <= fpos_in;
      free_ok_ff   <= free_ok_in;
      free_ff      <= free_in;
      mode_free_ff <= mode_free_in;
      ok_ff        <= ok_in;
      code_ff      <= code_in;
      newcap_ff    <= newcap_in;
      n_ff         <= n_in;
      k_ff         <= k_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/qphs_checker.sv
// Port-level checks for the quadratic probe hash set, bound to the top level.
module qphs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [qphs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import qphs_pkg::*;

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The table never holds more keys than it has slots.
   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:3] <= rsp_tdata[24:14])
      else $error("item count exceeds capacity");

   // The capacity is always a power of two.
   a_cap_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[24:14]))
      else $error("capacity is not a power of two");

   // Success goes with ok or a refused resize; failure never reports ok.
   a_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ?
         (rsp_tdata[2:1] == RC_OK || rsp_tdata[2:1] == RC_REFUSED) :
         (rsp_tdata[2:1] != RC_OK)))
      else $error("success flag disagrees with result code");

endmodule

bind quadratic_probe_hash_set qphs_checker u_qphs_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

### tb/sv/testbench.sv
// Self-checking testbench for the quadratic probe hash set.
`timescale 1ns / 100ps

module testbench;
   import qphs_pkg::*;

   localparam int MAX_CAP  = 1024;
   localparam int INIT_CAP = 16;
   localparam int POOL_N   = 48;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] hash;
   } set_req_t;

   typedef struct packed {
      logic        success;
      logic [1:0]  code;
      logic [10:0] count;
      logic [10:0] capacity;
   } set_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_MAX_LOAD;
   logic [7:0]  csr_wdata = '0;

   quadratic_probe_hash_set uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be driven, and responses the predictor says are due.
   set_req_t pending_reqs[$];
   set_rsp_t expected_rsps[$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int code_seen[4] = '{0, 0, 0, 0};
   int top_capacity = 0;

   // Predictor copy of the set: slot contents, home counts, size and thresholds.
   logic [31:0] tbl_key[MAX_CAP];
   logic [31:0] tbl_hash[MAX_CAP];
   logic        tbl_used[MAX_CAP];
   int          home_cnt[MAX_CAP];
   int          n_keys = 0;
   int          n_slots = INIT_CAP;
   int          max_lim = 192;
   int          min_lim = 64;

   // Triangular probe sequence, masked by the current capacity.
   function automatic int probe_at(logic [31:0] hash, int i);
      logic [63:0] pos;
      pos = {32'd0, hash} + (64'(i) + 64'(i) * 64'(i)) / 2;
      return int'(pos[10:0]) & (n_slots - 1);
   endfunction

   function automatic int locate(logic [31:0] key, logic [31:0] hash);
      int s;
      if (home_cnt[probe_at(hash, 0)] == 0) return -1;
      for (int i = 0; i < n_slots; i++) begin
         s = probe_at(hash, i);
         if (tbl_used[s] && tbl_key[s] == key) return s;
      end
      return -1;
   endfunction

   function automatic void store_key(logic [31:0] key, logic [31:0] hash);
      int s;
      home_cnt[probe_at(hash, 0)]++;
      for (int i = 0; i < n_slots; i++) begin
         s = probe_at(hash, i);
         if (!tbl_used[s]) begin
            tbl_used[s] = 1'b1;
            tbl_key[s] = key;
            tbl_hash[s] = hash;
            return;
         end
      end
   endfunction

   // Rebuild at a new capacity, reinserting live keys in ascending old-slot order.
   function automatic void rebuild(int new_slots);
      logic [31:0] keep_key[$];
      logic [31:0] keep_hash[$];
      for (int i = 0; i < n_slots; i++) begin
         if (tbl_used[i]) begin
            keep_key.push_back(tbl_key[i]);
            keep_hash.push_back(tbl_hash[i]);
         end
      end
      for (int i = 0; i < MAX_CAP; i++) begin
         tbl_used[i] = 1'b0;
         home_cnt[i] = 0;
      end
      n_slots = new_slots;
      n_keys = keep_key.size();
      foreach (keep_key[i]) store_key(keep_key[i], keep_hash[i]);
   endfunction

   function automatic set_rsp_t hash_set_apply(set_req_t r);
      set_rsp_t o;
      int s;
      o.success = 1'b0;
      o.code = RC_OK;
      if (r.key == 32'd0) begin
         o.code = RC_ABSENT;
      end else if (r.op == OP_INSERT) begin
         if (locate(r.key, r.hash) >= 0) begin
            o.code = RC_DUP;
         end else if (n_keys >= n_slots) begin
            o.code = RC_REFUSED;
         end else begin
            store_key(r.key, r.hash);
            n_keys++;
            o.success = 1'b1;
            if (longint'(n_keys) * 256 >= longint'(max_lim) * n_slots) begin
               if (n_slots * 2 > MAX_CAP) o.code = RC_REFUSED;
               else rebuild(n_slots * 2);
            end
         end
      end else if (r.op == OP_ERASE) begin
         s = locate(r.key, r.hash);
         if (s < 0) begin
            o.code = RC_ABSENT;
         end else begin
            home_cnt[probe_at(r.hash, 0)]--;
            tbl_used[s] = 1'b0;
            n_keys--;
            o.success = 1'b1;
            if (longint'(n_keys) * 256 <= longint'(min_lim) * n_slots) begin
               if (n_slots <= 1 || n_keys > n_slots / 2) o.code = RC_REFUSED;
               else rebuild(n_slots / 2);
            end
         end
      end else begin
         // Lookup; the spare operation code behaves the same way.
         if (locate(r.key, r.hash) >= 0) o.success = 1'b1;
         else o.code = RC_ABSENT;
      end
      o.count = 11'(n_keys);
      o.capacity = 11'(n_slots);
      return o;
   endfunction

   initial begin
      for (int i = 0; i < MAX_CAP; i++) begin
         tbl_used[i] = 1'b0;
         home_cnt[i] = 0;
      end
   end

   // Request driver: a new request is offered only once the previous one is taken,
   // so tvalid gets one assignment per edge and is never dropped while pending.
   always @(posedge clock) begin
      set_req_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {nxt.hash, nxt.key};
            req_tuser <= nxt.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side back-pressure, with one long hold that lets the block
   // fill up and stall its request input.
   always @(posedge clock) begin
      if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: tracks register writes, predicts each accepted request and checks
   // every accepted response against the oldest prediction.
   always @(posedge clock) begin
      set_req_t acc;
      set_rsp_t want;
      set_rsp_t got;
      if (!reset && csr_we) begin
         if (csr_index == CSR_MAX_LOAD) max_lim = csr_wdata;
         else min_lim = csr_wdata;
      end
      if (!reset && req_tvalid && req_tready) begin
         acc.op = req_tuser;
         acc.key = req_tdata[31:0];
         acc.hash = req_tdata[63:32];
         expected_rsps.push_back(hash_set_apply(acc));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.success = rsp_tdata[0];
         got.code = rsp_tdata[2:1];
         got.count = rsp_tdata[13:3];
         got.capacity = rsp_tdata[24:14];
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
         end else begin
            want = expected_rsps.pop_front();
            code_seen[got.code]++;
            if (got.capacity > top_capacity) top_capacity = got.capacity;
            if (got.success !== want.success) begin
               errors++;
               $display("%0t: success expected %0d actual %0d",
                        $time, want.success, got.success);
            end
            if (got.code !== want.code) begin
               errors++;
               $display("%0t: result code expected %0d actual %0d",
                        $time, want.code, got.code);
            end
            if (got.count !== want.count) begin
               errors++;
               $display("%0t: item count expected %0d actual %0d",
                        $time, want.count, got.count);
            end
            if (got.capacity !== want.capacity) begin
               errors++;
               $display("%0t: capacity expected %0d actual %0d",
                        $time, want.capacity, got.capacity);
            end
            if (rsp_tdata[31:25] !== 7'd0) begin
               errors++;
               $display("%0t: padding bits expected 0 actual %h", $time, rsp_tdata[31:25]);
            end
         end
      end
   end

   // Key pool with one fixed hash per key, so that inserts, erases and lookups
   // actually meet each other.
   logic [31:0] pool_key[POOL_N];
   logic [31:0] pool_hash[POOL_N];

   task automatic queue_req(logic [1:0] op, logic [31:0] key, logic [31:0] hash);
      set_req_t r;
      r.op = op;
      r.key = key;
      r.hash = hash;
      @(negedge clock);
      pending_reqs.push_back(r);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drain everything, then allow a little time for the block to settle.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_reqs(int count);
      int pick;
      int k;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) op = OP_INSERT;
         else if (pick < 75) op = OP_ERASE;
         else if (pick < 96) op = OP_LOOKUP;
         else op = 2'd3;
         pick = $urandom_range(99);
         k = $urandom_range(POOL_N - 1);
         if (pick < 83) queue_req(op, pool_key[k], pool_hash[k]);
         else if (pick < 88) queue_req(op, pool_key[k], $urandom);
         else if (pick < 98) queue_req(op, $urandom | 32'h1, $urandom);
         else queue_req(op, 32'd0, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < POOL_N; i++) begin
         do pool_key[i] = $urandom;
         while (pool_key[i] == 32'd0);
         pool_hash[i] = $urandom;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, key zero, duplicates and a
      // collision chain where four keys share one home slot.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_req(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
      queue_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
      queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(2'd3,      32'h0000_0001, 32'h0000_0000);
      queue_req(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
      queue_req(OP_ERASE,  32'h5555_AAAA, 32'hAAAA_5555);
      queue_req(OP_INSERT, 32'd0, 32'h0000_0003);
      queue_req(OP_ERASE,  32'd0, 32'h0000_0003);
      queue_req(OP_LOOKUP, 32'd0, 32'h0000_0003);
      for (int i = 0; i < 4; i++) queue_req(OP_INSERT, 32'h100 + i, 32'h0000_0005);
      queue_req(OP_LOOKUP, 32'h103, 32'h0000_0005);
      queue_req(OP_ERASE,  32'h101, 32'h0000_0005);
      queue_req(OP_LOOKUP, 32'h103, 32'h0000_0005);
      queue_req(OP_ERASE,  32'h0000_0001, 32'h0000_0000);
      queue_req(OP_ERASE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_quiet();

      // Lowest grow threshold: every insert doubles until the maximum capacity
      // refuses; then erasing everything with a zero shrink threshold, so only the last erase shrinks.
      write_csr(CSR_MAX_LOAD, 8'd1);
      write_csr(CSR_MIN_LOAD, 8'd0);
      for (int i = 0; i < 9; i++) queue_req(OP_INSERT, pool_key[i], pool_hash[i]);
      for (int i = 0; i < 9; i++) queue_req(OP_ERASE, pool_key[i], pool_hash[i]);
      for (int i = 0; i < 4; i++) queue_req(OP_ERASE, 32'h100 + i, 32'h0000_0005);
      wait_quiet();

      // Highest thresholds: erases shrink eagerly and inserts grow the table only once it is nearly full.
      write_csr(CSR_MAX_LOAD, 8'd255);
      write_csr(CSR_MIN_LOAD, 8'd254);
      send_idle_pct = 30;
      recv_stall_pct = 69;
      for (int i = 0; i < 6; i++) queue_req(OP_INSERT, pool_key[i], pool_hash[i]);
      for (int i = 0; i < 6; i++) queue_req(OP_ERASE, pool_key[i], pool_hash[i]);
      random_reqs(120);
      wait_quiet();

      // Reset defaults with the idling swapped.
      write_csr(CSR_MAX_LOAD, 8'd192);
      write_csr(CSR_MIN_LOAD, 8'd64);
      send_idle_pct = 69;
      recv_stall_pct = 30;
      random_reqs(130);
      wait_quiet();

      // Mid thresholds, no idling; a long receiver hold while requests keep coming.
      write_csr(CSR_MAX_LOAD, 8'd128);
      write_csr(CSR_MIN_LOAD, 8'd32);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(negedge clock);
      hold_trigger++;
      random_reqs(140);
      wait_quiet();
      repeat (50) @(negedge clock);

      $display("Covered inserts, erases and lookups under four threshold settings;");
      $display("result codes ok/dup/absent/refused = %0d/%0d/%0d/%0d, largest capacity %0d.",
               code_seen[0], code_seen[1], code_seen[2], code_seen[3], top_capacity);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far above the slowest correct run, full-table walks and rebuilds included.
   initial begin
      #500ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
